// ----- sv/lrupr_pkg.sv -----
// lrupr_pkg: shared types and constants for the LRU page replacement core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lrupr_pkg;

    localparam int IN_PAGE_W  = 16;
    localparam int OUT_PAGE_W = 16;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;
    localparam int STAMP_W    = 48;
    localparam int COUNT_W    = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_UPDATE
    } lrupr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the page of the accepted beat, clear scan results
        logic scan_rd;   // read one frame and advance the scan counter
        logic update;    // commit the replacement decision and load the result
    } lrupr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last; // the read issued this cycle is the last active frame
        logic out_free;  // result register can take a new beat
    } lrupr_status_t;

endpackage

`default_nettype wire

// ----- sv/lrupr_ctrl.sv -----
// lrupr_ctrl: sequencing state machine of the LRU page replacement core.
// Depends on lrupr_pkg for the state, command and status types.
`default_nettype none

module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lrupr_status_t status,
    output lrupr_cmd_t         cmd
);

    lrupr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.scan_rd = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
            end
            ST_FLUSH: begin
                // last frame's read data is compared in this cycle
            end
            ST_UPDATE: begin
                cmd.update = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lrupr_datapath.sv -----
// lrupr_datapath: frame memories, scan compare, stamp clock, totals and result register.
// Depends on lrupr_pkg; driven by lrupr_ctrl through lrupr_cmd_t / lrupr_status_t.
`default_nettype none

module lrupr_datapath
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lrupr_cmd_t            cmd,
    output lrupr_status_t              status,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data,
    input  wire logic [IN_PAGE_W-1:0]  in_page,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       out_hit,
    output logic [SLOT_W-1:0]          out_slot,
    output logic                       out_ev_valid,
    output logic [OUT_PAGE_W-1:0]      out_ev_page,
    output logic [COUNT_W-1:0]         out_fault_total,
    output logic [COUNT_W-1:0]         out_hit_total
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [7:0] FRAMES_8 = 8'(FRAMES);

    // frame store
    logic [PAGE_BITS-1:0] tag_mem   [FRAMES];
    logic [STAMP_W-1:0]   stamp_mem [FRAMES];
    logic [FRAMES-1:0]    valid_reg;

    logic [CFG_W-1:0]     cfg_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic [COUNT_W-1:0]   fault_reg;
    logic [COUNT_W-1:0]   hits_reg;

    // registered read port
    logic                 cmp_en_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 rd_valid_reg;
    logic [PAGE_BITS-1:0] rd_tag_reg;
    logic [STAMP_W-1:0]   rd_stamp_reg;

    // scan results
    logic                 found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [STAMP_W-1:0]   min_stamp_reg;
    logic [IDX_W-1:0]     min_idx_reg;
    logic [PAGE_BITS-1:0] min_tag_reg;

    // result register
    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic                  m_ev_valid_reg;
    logic [OUT_PAGE_W-1:0] m_ev_page_reg;

    logic [31:0]          page_ext;
    logic [PAGE_BITS-1:0] page_in;
    logic [7:0]           cfg_ext;
    logic [7:0]           active_8;
    logic [CNT_W-1:0]     active_cnt;
    logic [IDX_W-1:0]     rd_idx;
    logic                 match;
    logic                 evict;
    logic [IDX_W-1:0]     slot_idx;
    logic [31:0]          slot_ext;
    logic [31:0]          ev_tag_ext;
    logic [STAMP_W-1:0]   stamp_next;
    logic [COUNT_W-1:0]   fault_next;
    logic [COUNT_W-1:0]   hits_next;

    assign page_ext = 32'(in_page);
    assign page_in  = page_ext[PAGE_BITS-1:0];

    // zero acts as one frame, anything above FRAMES acts as FRAMES
    assign cfg_ext    = 8'(cfg_reg);
    assign active_8   = (cfg_ext == 8'd0) ? 8'd1 :
                        ((cfg_ext > FRAMES_8) ? FRAMES_8 : cfg_ext);
    assign active_cnt = active_8[CNT_W-1:0];

    assign rd_idx = cnt_reg[IDX_W-1:0];
    assign match  = rd_valid_reg && (rd_tag_reg == page_reg);

    assign evict      = !found_reg && !free_reg;
    assign slot_idx   = found_reg ? hit_idx_reg : (free_reg ? free_idx_reg : min_idx_reg);
    assign slot_ext   = 32'(slot_idx);
    assign ev_tag_ext = 32'(min_tag_reg);
    assign stamp_next = (stamp_reg != STAMP_MAX) ? stamp_reg + STAMP_W'(1) : stamp_reg;
    assign fault_next = (fault_reg != COUNT_MAX) ? fault_reg + COUNT_W'(1) : fault_reg;
    assign hits_next  = (hits_reg != COUNT_MAX) ? hits_reg + COUNT_W'(1) : hits_reg;

    assign status.scan_last = (cnt_reg == (active_cnt - CNT_W'(1)));
    assign status.out_free  = !m_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // memories: one read per scan cycle, one write in the update cycle
    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_tag_reg   <= tag_mem[rd_idx];
            rd_stamp_reg <= stamp_mem[rd_idx];
        end
        if (cmd.update) begin
            stamp_mem[slot_idx] <= stamp_next;
            if (!found_reg) begin
                tag_mem[slot_idx] <= page_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            page_reg <= page_in;
        end
        if (cmd.scan_rd) begin
            rd_valid_reg <= valid_reg[rd_idx];
            cmp_idx_reg  <= rd_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.scan_rd;
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (cmd.scan_rd) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // scan compare: first match, first empty frame, oldest stamp (lowest index on ties)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmd.load) begin
            found_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (cmp_en_reg) begin
            if (!found_reg && match) begin
                found_reg   <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!free_reg && !rd_valid_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (rd_stamp_reg < min_stamp_reg)) begin
                min_stamp_reg <= rd_stamp_reg;
                min_idx_reg   <= cmp_idx_reg;
                min_tag_reg   <= rd_tag_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            stamp_reg <= '0;
            fault_reg <= '0;
            hits_reg  <= '0;
        end else if (cmd.update) begin
            valid_reg[slot_idx] <= 1'b1;
            stamp_reg           <= stamp_next;
            if (found_reg) begin
                hits_reg <= hits_next;
            end else begin
                fault_reg <= fault_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_hit_reg      <= found_reg;
            m_slot_reg     <= slot_ext[SLOT_W-1:0];
            m_ev_valid_reg <= evict;
            m_ev_page_reg  <= evict ? ev_tag_ext[OUT_PAGE_W-1:0] : '0;
        end
    end

    assign out_valid       = m_valid_reg;
    assign out_hit         = m_hit_reg;
    assign out_slot        = m_slot_reg;
    assign out_ev_valid    = m_ev_valid_reg;
    assign out_ev_page     = m_ev_page_reg;
    assign out_fault_total = fault_reg;
    assign out_hit_total   = hits_reg;

    a_update_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || out_ready))
        else $error("result overwritten while a beat is pending");

    a_update_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid_reg)
        else $error("update did not produce a result beat");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_ev_valid_reg))
        else $error("hit reported with an eviction");

    a_no_evict_zero_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ev_valid_reg) |-> (m_ev_page_reg == '0))
        else $error("evicted page nonzero without eviction");

    a_one_total_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> (hits_reg == $past(hits_reg)) || (fault_reg == $past(fault_reg)))
        else $error("both totals changed on one reference");

endmodule

`default_nettype wire

// ----- sv/lru_page_replacement_core.sv -----
// lru_page_replacement_core: top level of the LRU (counter method) page replacement core.
// Depends on lrupr_pkg, lrupr_ctrl and lrupr_datapath.
//
//   channel   dir  handshake            payload
//   s_        in   s_valid / s_ready    s_page_number
//   m_        out  m_valid / m_ready    m_hit, m_slot, m_evicted_valid, m_evicted_page,
//                                       m_fault_total, m_hit_total
//   cfg_      in   cfg_wr_en            cfg_wr_data (frames_in_use)
//
// After accept, a reference passes through ST_SCAN (one frame read per active frame),
// ST_FLUSH (compare of the last read) and ST_UPDATE; a new beat is accepted only back
// in ST_IDLE, so each reference is finished before the next one is taken.
// The single read port of the frame memory sets the scan length, one frame a cycle.
// Reset (aresetn low, synchronous) clears valid bits, stamp clock and totals.
// A waiting result beat holds in the output register; the next beat is still accepted
// and scanned, and only its update cycle waits for m_ready.
`default_nettype none

module lru_page_replacement_core
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IN_PAGE_W-1:0]  s_page_number,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic [SLOT_W-1:0]          m_slot,
    output logic                       m_evicted_valid,
    output logic [OUT_PAGE_W-1:0]      m_evicted_page,
    output logic [COUNT_W-1:0]         m_fault_total,
    output logic [COUNT_W-1:0]         m_hit_total,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_W-1:0]      cfg_wr_data
);

    lrupr_cmd_t    cmd;
    lrupr_status_t status;

    lrupr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lrupr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_page         (s_page_number),
        .out_valid       (m_valid),
        .out_ready       (m_ready),
        .out_hit         (m_hit),
        .out_slot        (m_slot),
        .out_ev_valid    (m_evicted_valid),
        .out_ev_page     (m_evicted_page),
        .out_fault_total (m_fault_total),
        .out_hit_total   (m_hit_total)
    );

endmodule

`default_nettype wire
